@@ rtl/cll_pkg.sv @@
// Shared types and constants for the cursor linked list engine.
package cll_pkg;

   localparam int DEPTH_DEF = 1024;
   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int CNT_W = 10;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_RD,
      S_FREE_WT,
      S_WALK_RD,
      S_WALK_WT,
      S_TGT_RD,
      S_TGT_WT,
      S_WR1,
      S_WR2,
      S_WR3,
      S_WR4,
      S_WR5,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 cmd;
      logic [POS_W-1:0]     position;
      logic [VAL_W-1:0]     value;
      logic                 reject;
   } op_type;

endpackage

@@ rtl/cll_ram.sv @@
// Generic single-port RAM with registered read.
module cll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

@@ rtl/cll_front.sv @@
// Front end: takes items, range-checks them and holds them for the back end.
module cll_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      cmd,
   input  logic [cll_pkg::POS_W-1:0] position,
   input  logic [cll_pkg::VAL_W-1:0] value,
   input  logic [cll_pkg::CNT_W-1:0] count,
   input  logic                      q_pop,
   output logic                      q_valid,
   output cll_pkg::op_type           q_op
);
   // One-entry holding register. The range check uses the count as of the last
   // finished item, so only one item is let past into the back end at a time.
   cll_pkg::op_type ent_ff, ent_in;
   logic       valid_ff, valid_in;
   logic       take;
   logic       bad;
   logic [cll_pkg::CNT_W:0] cnt_x;

   always_comb begin
      cnt_x = {1'b0, count};
      if (cmd == cll_pkg::CMD_INSERT)
         bad = (position == '0) || ({1'b0, position} > cnt_x + 1'b1);
      else
         bad = (position == '0) || ({1'b0, position} > cnt_x);
   end

   assign full    = valid_ff;
   assign take    = push && !full;
   assign q_valid = valid_ff;
   assign q_op    = ent_ff;
   assign ent_in  = '{cmd: cmd, position: position, value: value, reject: bad};

   always_comb begin
      valid_in = valid_ff;
      if (q_pop && valid_ff) valid_in = 1'b0;
      if (take) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (take) ent_ff <= ent_in;
   end
endmodule

@@ rtl/cll_back.sv @@
// Back end: walks the link store and carries out inserts and deletes.
module cll_back #(
   parameter int DEPTH = cll_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  cll_pkg::op_type           q_op,
   output logic                      q_pop,
   output logic [cll_pkg::CNT_W-1:0] count,
   output logic                      r_valid,
   input  logic                      r_pop,
   output logic [1:0]                r_status,
   output logic [cll_pkg::CNT_W-1:0] r_length,
   output logic [cll_pkg::POS_W-1:0] r_slot
);
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] HEAD = AW'(DEPTH - 1);
   localparam logic [AW-1:0] LASTF = AW'(DEPTH - 2);

   cll_pkg::state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;       // clear sweep index
   logic [AW-1:0] k_ff, k_in;             // walk cursor
   logic [AW-1:0] j_ff, j_in;             // slot taken or freed
   logic [AW-1:0] nj_ff, nj_in;           // link of j
   logic [AW-1:0] nk_ff, nk_in;           // link of k, or free head on delete
   logic [cll_pkg::POS_W-1:0] n_ff, n_in; // links walked
   logic [cll_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic [1:0]    st_ff, st_in;
   logic [cll_pkg::POS_W-1:0] sl_ff, sl_in;

   logic          we;
   logic [AW-1:0] ra, wd, rd;
   logic [cll_pkg::VAL_W-1:0] vrd;
   logic          vwe;

   cll_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link (
      .clock(clock), .we(we), .addr(ra), .wdata(wd), .rdata(rd));
   cll_ram #(.WIDTH(cll_pkg::VAL_W), .DEPTH(DEPTH)) u_val (
      .clock(clock), .we(vwe), .addr(j_ff), .wdata(q_op.value), .rdata(vrd));

   assign count    = cnt_ff;
   assign r_valid  = rv_ff;
   assign r_status = st_ff;
   assign r_length = cnt_ff;
   assign r_slot   = sl_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cll_pkg::S_CLEAR:   if (addr_ff == HEAD) state_in = cll_pkg::S_IDLE;
         cll_pkg::S_IDLE:
            if (q_valid && !rv_ff) begin
               if (q_op.reject) state_in = cll_pkg::S_DONE;
               else if (q_op.cmd == cll_pkg::CMD_INSERT) state_in = cll_pkg::S_FREE_RD;
               else state_in = cll_pkg::S_WALK_RD;
            end
         cll_pkg::S_FREE_RD: state_in = cll_pkg::S_FREE_WT;
         cll_pkg::S_FREE_WT:
            if (rd == '0) state_in = cll_pkg::S_DONE;
            else state_in = cll_pkg::S_WALK_RD;
         cll_pkg::S_WALK_RD:
            if (n_ff >= q_op.position) state_in = cll_pkg::S_TGT_RD;
            else state_in = cll_pkg::S_WALK_WT;
         cll_pkg::S_WALK_WT: state_in = cll_pkg::S_WALK_RD;
         cll_pkg::S_TGT_RD:  state_in = cll_pkg::S_TGT_WT;
         cll_pkg::S_TGT_WT:  state_in = cll_pkg::S_WR1;
         cll_pkg::S_WR1:     state_in = cll_pkg::S_WR2;
         cll_pkg::S_WR2:     state_in = cll_pkg::S_WR3;
         cll_pkg::S_WR3:     state_in = cll_pkg::S_WR4;
         cll_pkg::S_WR4:     state_in = cll_pkg::S_WR5;
         cll_pkg::S_WR5:     state_in = cll_pkg::S_DONE;
         cll_pkg::S_DONE:    state_in = cll_pkg::S_IDLE;
         default:            state_in = cll_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      addr_in = addr_ff; k_in = k_ff; j_in = j_ff; nj_in = nj_ff; nk_in = nk_ff;
      n_in = n_ff; cnt_in = cnt_ff; rv_in = rv_ff; st_in = st_ff; sl_in = sl_ff;
      we = 1'b0; ra = k_ff; wd = '0; vwe = 1'b0; q_pop = 1'b0;
      if (rv_ff && r_pop) rv_in = 1'b0;
      case (state_ff)
         cll_pkg::S_CLEAR: begin
            we = 1'b1; ra = addr_ff;
            wd = (addr_ff >= LASTF) ? '0 : addr_ff + 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         cll_pkg::S_IDLE: begin
            k_in = HEAD; n_in = cll_pkg::POS_W'(1);
            // A waiting result keeps its fields until a new item starts.
            if (q_valid && !rv_ff) begin
               st_in = cll_pkg::ST_OK; sl_in = '0;
            end
         end
         cll_pkg::S_FREE_RD: ra = '0;
         cll_pkg::S_FREE_WT: begin
            j_in = rd;
            if (rd == '0) st_in = cll_pkg::ST_FULL;
         end
         cll_pkg::S_WALK_RD: begin
            ra = k_ff;
            if (n_ff < q_op.position) n_in = n_ff + 1'b1;
         end
         cll_pkg::S_WALK_WT: k_in = rd;
         cll_pkg::S_TGT_RD: ra = k_ff;
         cll_pkg::S_TGT_WT: begin
            nk_in = rd;
            if (q_op.cmd == cll_pkg::CMD_DELETE) j_in = rd;
         end
         cll_pkg::S_WR1: begin
            // Read link of j: the next element (delete) or the next free slot (insert).
            ra = j_ff;
         end
         cll_pkg::S_WR2: begin
            nj_in = rd;
            ra = '0;
         end
         cll_pkg::S_WR3: begin
            we = 1'b1; ra = k_ff;
            if (q_op.cmd == cll_pkg::CMD_INSERT) begin
               wd = j_ff; vwe = 1'b1;
            end else begin
               // The free head read in the previous cycle becomes the link of j.
               wd = nj_ff; nk_in = rd;
            end
         end
         cll_pkg::S_WR4: begin
            we = 1'b1; ra = j_ff; wd = nk_ff;
         end
         cll_pkg::S_WR5: begin
            we = 1'b1; ra = '0;
            wd = (q_op.cmd == cll_pkg::CMD_INSERT) ? nj_ff : j_ff;
         end
         cll_pkg::S_DONE: begin
            q_pop = 1'b1; rv_in = 1'b1;
            if (q_op.reject) st_in = cll_pkg::ST_RANGE;
            else if (st_ff == cll_pkg::ST_OK) begin
               sl_in = cll_pkg::POS_W'(j_ff);
               if (q_op.cmd == cll_pkg::CMD_INSERT) cnt_in = cnt_ff + 1'b1;
               else cnt_in = cnt_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cll_pkg::S_CLEAR; addr_ff <= '0; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; addr_ff <= addr_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
      k_ff <= k_in; j_ff <= j_in; nj_ff <= nj_in; nk_ff <= nk_in; n_ff <= n_in;
      st_ff <= st_in; sl_ff <= sl_in;
   end
endmodule

@@ rtl/cursor_linked_list_engine_unit.sv @@
// Top level of the cursor linked list engine.
//  channel | ports                                   | direction
//  request | req_push req_full req_cmd req_position req_value | in
//  result  | rsp_empty rsp_pop rsp_status rsp_length rsp_slot | out
// The time an insert or a delete spends in the back end is set by the walk
// through the link memory, one link after another; a rejected item skips the
// walk. After reset a clearing pass over every slot builds the free chain; one
// item may wait in the front register meanwhile. A waiting result holds the back
// end until it is popped, and the front takes the next item only once the back
// end has finished the previous one.
module cursor_linked_list_engine_unit #(
   parameter int DEPTH = cll_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_cmd,
   input  logic [cll_pkg::POS_W-1:0] req_position,
   input  logic [cll_pkg::VAL_W-1:0] req_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [1:0]                rsp_status,
   output logic [cll_pkg::CNT_W-1:0] rsp_length,
   output logic [cll_pkg::POS_W-1:0] rsp_slot
);
   logic q_valid, q_pop, r_valid;
   cll_pkg::op_type q_op;
   logic [cll_pkg::CNT_W-1:0] count;

   cll_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .cmd(req_cmd), .position(req_position), .value(req_value), .count(count),
      .q_pop(q_pop), .q_valid(q_valid), .q_op(q_op));

   cll_back #(.DEPTH(DEPTH)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop),
      .count(count), .r_valid(r_valid), .r_pop(rsp_pop), .r_status(rsp_status),
      .r_length(rsp_length), .r_slot(rsp_slot));

   assign rsp_empty = !r_valid;

   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      (r_valid && rsp_status != cll_pkg::ST_OK) |-> rsp_slot == '0)
      else $error("failed item reports a slot");
endmodule

@@ test/cursor_linked_list_engine_unit_chk.sv @@
// Checker for the cursor linked list engine: predicts each result and compares it.
module cursor_linked_list_engine_unit_chk #(
   parameter int DEPTH = cll_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic                      req_cmd,
   input  logic [cll_pkg::POS_W-1:0] req_position,
   input  logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  logic [1:0]                rsp_status,
   input  logic [cll_pkg::CNT_W-1:0] rsp_length,
   input  logic [cll_pkg::POS_W-1:0] rsp_slot,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      cll_pkg::status_type       status;
      logic [cll_pkg::CNT_W-1:0] length;
      logic [cll_pkg::POS_W-1:0] slot;
   } outcome_type;

   logic [cll_pkg::POS_W-1:0] links [DEPTH];
   logic [cll_pkg::CNT_W-1:0] elem_count;
   outcome_type               outcome_q [$];

   function automatic logic [cll_pkg::POS_W-1:0] next_of(
      input logic [cll_pkg::POS_W-1:0] s);
      logic [cll_pkg::POS_W-1:0] l;
      l = (s < DEPTH) ? links[s] : links[0];
      return (l < DEPTH) ? l : '0;
   endfunction

   // Slot whose link points at list position pos.
   function automatic logic [cll_pkg::POS_W-1:0] slot_before(
      input logic [cll_pkg::POS_W-1:0] pos);
      logic [cll_pkg::POS_W-1:0] k;
      k = cll_pkg::POS_W'(DEPTH - 1);
      for (int n = 1; n < pos && n < DEPTH; n++) k = next_of(k);
      return k;
   endfunction

   function automatic outcome_type apply_op(input logic cmd,
                                            input logic [cll_pkg::POS_W-1:0] pos);
      outcome_type o;
      logic [cll_pkg::POS_W-1:0] j, k;
      o = '{cll_pkg::ST_OK, '0, '0};
      if (cmd == cll_pkg::CMD_INSERT) begin
         if (pos < 1 || pos > elem_count + 1) begin
            o.status = cll_pkg::ST_RANGE;
         end else begin
            j = next_of('0);
            if (j == 0) begin
               o.status = cll_pkg::ST_FULL;
            end else begin
               links[0] = next_of(j);
               k = slot_before(pos);
               links[j] = next_of(k);
               links[k] = j;
               elem_count++;
               o.slot = j;
            end
         end
      end else begin
         if (pos < 1 || pos > elem_count) begin
            o.status = cll_pkg::ST_RANGE;
         end else begin
            k = slot_before(pos);
            j = next_of(k);
            links[k] = next_of(j);
            links[j] = next_of('0);
            links[0] = j;
            elem_count--;
            o.slot = j;
         end
      end
      o.length = elem_count;
      return o;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) links[i] = cll_pkg::POS_W'(i + 1);
         links[DEPTH-2] = '0;
         links[DEPTH-1] = '0;
         elem_count = '0;
         outcome_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (outcome_q.size() == 0) begin
               report("unexpected result", 32'(rsp_status), 32'd0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_length !== want.length)
                  report("length", 32'(rsp_length), 32'(want.length));
               if (rsp_slot !== want.slot)
                  report("slot", 32'(rsp_slot), 32'(want.slot));
            end
         end
         if (req_push && !req_full) outcome_q.push_back(apply_op(req_cmd, req_position));
      end
      pending = outcome_q.size();
   end

endmodule

@@ test/cursor_linked_list_engine_unit_tb.sv @@
// Testbench top for the cursor linked list engine: stimulus, watchdog and verdict.
module cursor_linked_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = cll_pkg::DEPTH_DEF;
   localparam int STALL_LIMIT = 20000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic                      req_cmd = cll_pkg::CMD_INSERT;
   logic [cll_pkg::POS_W-1:0] req_position = '0;
   logic [cll_pkg::VAL_W-1:0] req_value = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [1:0]                rsp_status;
   logic [cll_pkg::CNT_W-1:0] rsp_length;
   logic [cll_pkg::POS_W-1:0] rsp_slot;
   int                        fail_count;
   int                        pending;
   int                        list_len = 0;
   int                        idle_cycles = 0;

   always #5 clock = ~clock;

   cursor_linked_list_engine_unit #(.DEPTH(DEPTH)) u_dut (.*);

   cursor_linked_list_engine_unit_chk #(.DEPTH(DEPTH)) u_chk (.*);

   // Draws a wait, with stretches where no waiting happens at all.
   function automatic int draw_wait(input int n);
      return ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 17);
   endfunction

   // Sends one item; list_len follows the length the block will report.
   task automatic send_item(input logic cmd, input int pos,
                            input logic [cll_pkg::VAL_W-1:0] val);
      int gap;
      gap = draw_wait($urandom_range(0, 119));
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_position <= pos[cll_pkg::POS_W-1:0];
      req_value <= val;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      if (cmd == cll_pkg::CMD_INSERT && pos >= 1 && pos <= list_len + 1
          && list_len < DEPTH - 2)
         list_len++;
      else if (cmd == cll_pkg::CMD_DELETE && pos >= 1 && pos <= list_len)
         list_len--;
   endtask

   function automatic logic [cll_pkg::VAL_W-1:0] rand_value();
      return $urandom();
   endfunction

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: pops with random waits between items.
   initial begin
      int n;
      int w;
      n = 0;
      @(negedge clock);
      forever begin
         w = draw_wait(n + 20);
         if (w > 0) begin
            rsp_pop <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         @(negedge clock);
         n++;
      end
   end

   initial begin
      int r;
      int p;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty list, extremes of fields, ends and middle of the list.
      send_item(cll_pkg::CMD_DELETE, 1, '0);
      send_item(cll_pkg::CMD_INSERT, 0, 32'h7fffffff);
      send_item(cll_pkg::CMD_INSERT, 2, 32'h7fffffff);
      send_item(cll_pkg::CMD_INSERT, 1023, 32'hffffffff);
      send_item(cll_pkg::CMD_INSERT, 1, 32'h7fffffff);
      send_item(cll_pkg::CMD_INSERT, 2, 32'h80000000);
      send_item(cll_pkg::CMD_INSERT, 1, 32'hffffffff);
      send_item(cll_pkg::CMD_INSERT, 4, 32'h00000000);
      send_item(cll_pkg::CMD_INSERT, 3, 32'h12345678);
      send_item(cll_pkg::CMD_INSERT, 7, 32'h1);
      send_item(cll_pkg::CMD_DELETE, 0, 32'hffffffff);
      send_item(cll_pkg::CMD_DELETE, 6, '0);
      send_item(cll_pkg::CMD_DELETE, 1023, '0);
      send_item(cll_pkg::CMD_DELETE, 5, '0);
      send_item(cll_pkg::CMD_DELETE, 1, '0);
      send_item(cll_pkg::CMD_DELETE, 2, '0);
      send_item(cll_pkg::CMD_INSERT, 4, 32'hdeadbeef);

      // Random part: mostly valid operations, some noise, length kept moderate.
      for (int i = 0; i < 530; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023), rand_value());
         end else if (r < (list_len > 120 ? 35 : 62)) begin
            send_item(cll_pkg::CMD_INSERT, $urandom_range(1, list_len + 1), rand_value());
         end else begin
            p = (list_len > 0) ? $urandom_range(1, list_len) : 1;
            send_item(cll_pkg::CMD_DELETE, p, rand_value());
         end
      end

      // Positions just past the ends of the list and past the store.
      send_item(cll_pkg::CMD_INSERT, list_len + 2, rand_value());
      send_item(cll_pkg::CMD_DELETE, list_len + 1, rand_value());
      send_item(cll_pkg::CMD_INSERT, DEPTH - 1, rand_value());
      send_item(cll_pkg::CMD_INSERT, DEPTH, rand_value());
      for (int i = 0; i < 30; i++) begin
         p = (list_len > 0) ? $urandom_range(1, list_len) : 1;
         send_item(cll_pkg::CMD_DELETE, p, rand_value());
      end

      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
